### rtl/tsb_pkg.sv
// ---------------------------------------------------------------------------
// tsb_pkg
// Shared types, codes and coordinate folding for the texture sampler.
// ---------------------------------------------------------------------------
package tsb_pkg;

    typedef logic [7:0]  t_chan;
    typedef logic [23:0] t_texel;
    typedef logic [16:0] t_tcoord;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] BORDER_REPEAT = 2'd0;
    localparam logic [1:0] BORDER_MIRROR = 2'd1;
    localparam logic [1:0] BORDER_CLAMP  = 2'd2;

    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    localparam logic [1:0] CFG_BORDER = 2'd0;
    localparam logic [1:0] CFG_FILTER = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam int CFG_DW = 9;

    // fold a signed q16.16 coordinate into q1.16 in [0, 1.0]
    function automatic t_tcoord fold_coord(input logic [31:0] raw, input logic [1:0] mode);
        t_tcoord frac;
        t_tcoord res;
        frac = {1'b0, raw[15:0]};
        case (mode)
            BORDER_MIRROR: begin
                res = raw[16] ? (17'h10000 - frac) : frac;
            end
            BORDER_CLAMP: begin
                if (raw[31]) begin
                    res = '0;
                end else if (raw > 32'h10000) begin
                    res = 17'h10000;
                end else begin
                    res = raw[16:0];
                end
            end
            default: begin
                res = frac;
            end
        endcase
        return res;
    endfunction

endpackage

### rtl/tsb_in_if.sv
// ---------------------------------------------------------------------------
// tsb_in_if
// Input channel: texel writes and sample requests.
// ---------------------------------------------------------------------------
interface tsb_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    tsb_pkg::t_chan       texel_x;
    tsb_pkg::t_chan       texel_y;
    tsb_pkg::t_chan       texel_red;
    tsb_pkg::t_chan       texel_green;
    tsb_pkg::t_chan       texel_blue;
    logic signed [31:0]   coord_u;
    logic signed [31:0]   coord_v;

    modport source (output valid, action, texel_x, texel_y, texel_red, texel_green,
                    texel_blue, coord_u, coord_v, input ready);
    modport sink   (input valid, action, texel_x, texel_y, texel_red, texel_green,
                    texel_blue, coord_u, coord_v, output ready);
endinterface

### rtl/tsb_out_if.sv
// ---------------------------------------------------------------------------
// tsb_out_if
// Output channel: sampled colors.
// ---------------------------------------------------------------------------
interface tsb_out_if;
    logic           valid;
    logic           ready;
    tsb_pkg::t_chan red;
    tsb_pkg::t_chan green;
    tsb_pkg::t_chan blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/tsb_ram.sv
// ---------------------------------------------------------------------------
// tsb_ram
// One texel bank: one write port, one registered read port with enable.
// ---------------------------------------------------------------------------
module tsb_ram #(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    logic [23:0] r_mem [2**AW];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/texture_sampler_border_bilinear.sv
// ---------------------------------------------------------------------------
// texture_sampler_border_bilinear
// Texel store in four parity banks with border folding and nearest or
// bilinear filtering.
//
//   channel   dir  payload                                        per transfer
//   i_in      in   action, texel x/y/rgb, coord_u, coord_v        one item
//   o_out     out  red, green, blue                               one sample result
//   cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data                one register
//
// one item per cycle while the output does not stall; a sample result passes
// stages a to e and the output register; the four texels of a bilinear
// footprint come from four banks split by x and y parity, one read each per cycle
// a write reaches its bank from stage b, after the stage a and b registers,
// ahead of any later sample read
// stalls on the output fill the stages back to the input; bubbles collapse
// reset clears valid flags and configuration registers; the texel store is not cleared
// ---------------------------------------------------------------------------
module texture_sampler_border_bilinear #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tsb_in_if.sink                     i_in,
    tsb_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [tsb_pkg::CFG_DW-1:0] i_cfg_data
);
    import tsb_pkg::*;

    localparam int XW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
    localparam int YW = (MAX_HEIGHT > 4) ? $clog2(MAX_HEIGHT) : 2;
    localparam int AW = (XW - 1) + (YW - 1);

    // configuration
    logic [1:0] r_border;
    logic       r_filter;
    logic [8:0] r_w, r_wm1, r_h, r_hm1;

    function automatic logic [8:0] lim(input logic [8:0] s, input int maxv);
        logic [8:0] res;
        if (s == 9'd0) begin
            res = 9'd1;
        end else if (32'(s) > maxv) begin
            res = 9'(maxv);
        end else begin
            res = s;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border <= BORDER_REPEAT;
            r_filter <= FILTER_NEAREST;
            r_w      <= lim(9'd256, MAX_WIDTH);
            r_wm1    <= lim(9'd256, MAX_WIDTH) - 9'd1;
            r_h      <= lim(9'd256, MAX_HEIGHT);
            r_hm1    <= lim(9'd256, MAX_HEIGHT) - 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BORDER: r_border <= i_cfg_data[1:0];
                CFG_FILTER: r_filter <= i_cfg_data[0];
                CFG_WIDTH: begin
                    r_w   <= lim(i_cfg_data, MAX_WIDTH);
                    r_wm1 <= lim(i_cfg_data, MAX_WIDTH) - 9'd1;
                end
                CFG_HEIGHT: begin
                    r_h   <= lim(i_cfg_data, MAX_HEIGHT);
                    r_hm1 <= lim(i_cfg_data, MAX_HEIGHT) - 9'd1;
                end
                default: ;
            endcase
        end
    end

    // stage valids and flow control
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vo;
    logic f_a, f_b, f_c, f_d, f_e, f_o;

    logic        r_a_act;
    t_chan       r_a_x, r_a_y, r_a_r, r_a_g, r_a_b;
    logic [31:0] r_a_u, r_a_v;

    logic        r_b_act;
    t_chan       r_b_x, r_b_y;
    t_texel      r_b_rgb;
    logic [25:0] r_b_pu, r_b_pv;

    assign f_o = !r_vo || o_out.ready;
    assign f_e = !r_ve || f_o;
    assign f_d = !r_vd || f_e;
    assign f_c = !r_vc || f_d;
    assign f_b = !r_vb || (r_b_act == ACT_WRITE) || f_c;
    assign f_a = !r_va || f_b;
    assign i_in.ready = f_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (f_a) r_va <= i_in.valid;
            if (f_b) r_vb <= r_va;
            if (f_c) r_vc <= r_vb && (r_b_act == ACT_SAMPLE);
            if (f_d) r_vd <= r_vc;
            if (f_e) r_ve <= r_vd;
            if (f_o) r_vo <= r_ve;
        end
    end

    // stage a: input register
    always_ff @(posedge i_clk) begin
        if (f_a) begin
            r_a_act <= i_in.action;
            r_a_x   <= i_in.texel_x;
            r_a_y   <= i_in.texel_y;
            r_a_r   <= i_in.texel_red;
            r_a_g   <= i_in.texel_green;
            r_a_b   <= i_in.texel_blue;
            r_a_u   <= i_in.coord_u;
            r_a_v   <= i_in.coord_v;
        end
    end

    // stage b: fold and scale
    t_tcoord    c_tu, c_tv;
    logic [8:0] c_su, c_sv;
    assign c_tu = fold_coord(r_a_u, r_border);
    assign c_tv = fold_coord(r_a_v, r_border);
    assign c_su = (r_filter == FILTER_BILINEAR) ? r_wm1 : r_w;
    assign c_sv = (r_filter == FILTER_BILINEAR) ? r_hm1 : r_h;

    always_ff @(posedge i_clk) begin
        if (f_b) begin
            r_b_act <= r_a_act;
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            r_b_rgb <= {r_a_r, r_a_g, r_a_b};
            r_b_pu  <= {9'd0, c_tu} * {17'd0, c_su};
            r_b_pv  <= {9'd0, c_tv} * {17'd0, c_sv};
        end
    end

    // stage b: indices, weights, bank access
    logic       c_bil;
    logic [9:0] c_wm1, c_hm1, c_x0, c_x1, c_y0, c_y1;
    t_chan      c_fu, c_fv;
    assign c_bil = (r_filter == FILTER_BILINEAR);
    assign c_wm1 = {1'b0, r_wm1};
    assign c_hm1 = {1'b0, r_hm1};
    assign c_x0  = (r_b_pu[25:16] > c_wm1) ? c_wm1 : r_b_pu[25:16];
    assign c_y0  = (r_b_pv[25:16] > c_hm1) ? c_hm1 : r_b_pv[25:16];
    assign c_x1  = (c_bil && c_x0 < c_wm1) ? c_x0 + 10'd1 : c_x0;
    assign c_y1  = (c_bil && c_y0 < c_hm1) ? c_y0 + 10'd1 : c_y0;
    assign c_fu  = c_bil ? r_b_pu[15:8] : '0;
    assign c_fv  = c_bil ? r_b_pv[15:8] : '0;

    logic          c_wr;
    logic [XW-1:0] c_wx;
    logic [YW-1:0] c_wy;
    assign c_wr = r_vb && (r_b_act == ACT_WRITE) && (32'(r_b_x) < MAX_WIDTH)
                  && (32'(r_b_y) < MAX_HEIGHT);
    assign c_wx = XW'(r_b_x);
    assign c_wy = YW'(r_b_y);

    t_texel c_rd [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [9:0]    xs, ys;
        logic [XW-1:0] xc;
        logic [YW-1:0] yc;
        logic          we;
        assign xs = (c_x0[0] == 1'(b % 2)) ? c_x0 : c_x1;
        assign ys = (c_y0[0] == 1'(b / 2)) ? c_y0 : c_y1;
        assign xc = XW'(xs);
        assign yc = YW'(ys);
        assign we = c_wr && (c_wx[0] == 1'(b % 2)) && (c_wy[0] == 1'(b / 2));

        tsb_ram #(.AW(AW)) u_ram (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr({c_wy[YW-1:1], c_wx[XW-1:1]}),
            .i_wdata(r_b_rgb),
            .i_re   (f_c),
            .i_raddr({yc[YW-1:1], xc[XW-1:1]}),
            .o_rdata(c_rd[b])
        );
    end

    // stage c: bank data arrives
    logic  r_c_x0p, r_c_x1p, r_c_y0p, r_c_y1p;
    t_chan r_c_fu, r_c_fv;

    always_ff @(posedge i_clk) begin
        if (f_c) begin
            r_c_x0p <= c_x0[0];
            r_c_x1p <= c_x1[0];
            r_c_y0p <= c_y0[0];
            r_c_y1p <= c_y1[0];
            r_c_fu  <= c_fu;
            r_c_fv  <= c_fv;
        end
    end

    // stage d: weights and selected texels (00, 01, 10, 11)
    logic [8:0]  c_au, c_av;
    logic [17:0] c_wp [4];
    assign c_au = 9'd256 - {1'b0, r_c_fu};
    assign c_av = 9'd256 - {1'b0, r_c_fv};
    assign c_wp[0] = {9'd0, c_au} * {9'd0, c_av};
    assign c_wp[1] = {9'd0, c_au} * {10'd0, r_c_fv};
    assign c_wp[2] = {10'd0, r_c_fu} * {9'd0, c_av};
    assign c_wp[3] = {10'd0, r_c_fu} * {10'd0, r_c_fv};

    logic [16:0] r_d_w [4];
    t_texel      r_d_t [4];

    always_ff @(posedge i_clk) begin
        if (f_d) begin
            for (int k = 0; k < 4; k++) begin
                r_d_w[k] <= c_wp[k][16:0];
            end
            r_d_t[0] <= c_rd[{r_c_y0p, r_c_x0p}];
            r_d_t[1] <= c_rd[{r_c_y1p, r_c_x0p}];
            r_d_t[2] <= c_rd[{r_c_y0p, r_c_x1p}];
            r_d_t[3] <= c_rd[{r_c_y1p, r_c_x1p}];
        end
    end

    // stage e: weighted channels
    logic [24:0] r_e_p [4][3];

    always_ff @(posedge i_clk) begin
        if (f_e) begin
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_e_p[k][c] <= {8'd0, r_d_w[k]} * {17'd0, r_d_t[k][8*(2-c) +: 8]};
                end
            end
        end
    end

    // output register: sum, round, saturate
    logic [26:0] c_sum [3];
    t_chan       c_res [3];
    t_chan       r_o_c [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c_sum[c] = 27'(r_e_p[0][c]) + 27'(r_e_p[1][c]) + 27'(r_e_p[2][c])
                       + 27'(r_e_p[3][c]) + 27'd32768;
            c_res[c] = (c_sum[c][26:24] != 3'd0) ? 8'hff : c_sum[c][23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_o) begin
            for (int c = 0; c < 3; c++) begin
                r_o_c[c] <= c_res[c];
            end
        end
    end

    assign o_out.valid = r_vo;
    assign o_out.red   = r_o_c[0];
    assign o_out.green = r_o_c[1];
    assign o_out.blue  = r_o_c[2];
endmodule

### rtl/tsb_chk.sv
// ---------------------------------------------------------------------------
// tsb_chk
// Port-level checks on the texture sampler, bound to the top level.
// ---------------------------------------------------------------------------
module tsb_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_out_data
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    // a result needs a full pipeline pass since reset
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
                        && $past(i_rst_n, 4) && $past(i_rst_n, 5))
        else $error("result too early after reset");

    // an empty output side leaves the input open
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(!i_out_valid) && $past(!i_out_valid, 2) && $past(i_rst_n, 6)
        && $past(!i_out_valid, 3) && $past(!i_out_valid, 4) && $past(!i_out_valid, 5)
        |-> i_in_ready)
        else $error("input blocked with idle output");
endmodule

bind texture_sampler_border_bilinear tsb_chk u_tsb_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data ({o_out.red, o_out.green, o_out.blue})
);

### dv/texture_sampler_border_bilinear_test.sv
// ---------------------------------------------------------------------------
// texture_sampler_border_bilinear_test
// Self-checking bench for the texture sampler. Texel writes and samples go in
// over a valid/ready channel in random bursts, and the output stalls on its
// own pattern. The bench keeps its own texel store and register copy and
// predicts every sampled color. Before each sample it loads every texel in
// the footprint that has not been written yet. Runs cover all border and
// filter modes and size registers including 0, 1, 256 and out of range.
// ---------------------------------------------------------------------------
module texture_sampler_border_bilinear_test;
    import tsb_pkg::*;

    localparam int STORE_W = 256;
    localparam int STORE_H = 256;
    localparam int DRAIN_CYCLES = 20;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        t_chan r;
        t_chan g;
        t_chan b;
    } t_rgb;

    typedef struct {
        int x0;
        int x1;
        int y0;
        int y1;
        int fu;
        int fv;
    } t_footprint;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    tsb_in_if  in_ch ();
    tsb_out_if out_ch ();

    texture_sampler_border_bilinear #(
        .MAX_WIDTH  (STORE_W),
        .MAX_HEIGHT (STORE_H)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_texel texels [0:STORE_W*STORE_H-1];
    bit     written [0:STORE_W*STORE_H-1];
    t_rgb   colors_due [$];

    logic [1:0]        sh_border;
    logic              sh_filter;
    logic [CFG_DW-1:0] sh_width;
    logic [CFG_DW-1:0] sh_height;

    int     mismatches;
    longint cycles;
    int     burst_left;
    int     hold_request;
    int     hold_left;
    int     seg_left;
    int     seg_kind;

    always #6 i_clk = ~i_clk;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BORDER;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_WRITE;
        in_ch.texel_x = '0;
        in_ch.texel_y = '0;
        in_ch.texel_red = '0;
        in_ch.texel_green = '0;
        in_ch.texel_blue = '0;
        in_ch.coord_u = '0;
        in_ch.coord_v = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: segments of always ready, random stalls and heavy stalls
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 150);
                seg_kind = $urandom_range(0, 2);
            end
            seg_left--;
            case (seg_kind)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result check against the oldest predicted color
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (colors_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result r=%0d g=%0d b=%0d",
                             out_ch.red, out_ch.green, out_ch.blue);
                end
            end else begin
                want = colors_due.pop_front();
                if (out_ch.red !== want.r || out_ch.green !== want.g ||
                    out_ch.blue !== want.b) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("color mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.r, want.g, want.b,
                                 out_ch.red, out_ch.green, out_ch.blue);
                    end
                end
            end
        end
    end

    function automatic int eff_size(logic [CFG_DW-1:0] s, int maxv);
        if (s == 0) return 1;
        if (s > maxv) return maxv;
        return int'(s);
    endfunction

    function automatic int fold_axis(logic [31:0] raw);
        int frac;
        frac = int'(raw[15:0]);
        case (sh_border)
            BORDER_MIRROR: return raw[16] ? 65536 - frac : frac;
            BORDER_CLAMP: begin
                if (raw[31]) return 0;
                if (raw > 32'h10000) return 65536;
                return int'(raw[16:0]);
            end
            default: return frac;
        endcase
    endfunction

    function automatic t_footprint footprint(logic [31:0] u, logic [31:0] v);
        t_footprint f;
        int ew;
        int eh;
        longint pu;
        longint pv;
        ew = eff_size(sh_width, STORE_W);
        eh = eff_size(sh_height, STORE_H);
        if (sh_filter == FILTER_NEAREST) begin
            pu = longint'(fold_axis(u)) * ew;
            pv = longint'(fold_axis(v)) * eh;
            f.x0 = int'(pu >> 16);
            f.y0 = int'(pv >> 16);
            if (f.x0 > ew - 1) f.x0 = ew - 1;
            if (f.y0 > eh - 1) f.y0 = eh - 1;
            f.x1 = f.x0;
            f.y1 = f.y0;
            f.fu = 0;
            f.fv = 0;
        end else begin
            pu = longint'(fold_axis(u)) * (ew - 1);
            pv = longint'(fold_axis(v)) * (eh - 1);
            f.x0 = int'(pu >> 16);
            f.y0 = int'(pv >> 16);
            f.fu = int'((pu >> 8) & 255);
            f.fv = int'((pv >> 8) & 255);
            f.x1 = (f.x0 + 1 > ew - 1) ? ew - 1 : f.x0 + 1;
            f.y1 = (f.y0 + 1 > eh - 1) ? eh - 1 : f.y0 + 1;
        end
        return f;
    endfunction

    function automatic t_rgb blend_color(t_footprint f);
        t_rgb res;
        t_texel t00;
        t_texel t01;
        t_texel t10;
        t_texel t11;
        longint s;
        longint r;
        int sh;
        t00 = texels[f.y0*STORE_W + f.x0];
        t01 = texels[f.y1*STORE_W + f.x0];
        t10 = texels[f.y0*STORE_W + f.x1];
        t11 = texels[f.y1*STORE_W + f.x1];
        for (int k = 0; k < 3; k++) begin
            sh = 16 - 8*k;
            s = longint'((256 - f.fu) * (256 - f.fv)) * ((t00 >> sh) & 8'hff)
              + longint'((256 - f.fu) * f.fv) * ((t01 >> sh) & 8'hff)
              + longint'(f.fu * (256 - f.fv)) * ((t10 >> sh) & 8'hff)
              + longint'(f.fu * f.fv) * ((t11 >> sh) & 8'hff);
            r = (s + 32768) >> 16;
            if (r > 255) r = 255;
            case (k)
                0: res.r = t_chan'(r);
                1: res.g = t_chan'(r);
                default: res.b = t_chan'(r);
            endcase
        end
        return res;
    endfunction

    task automatic send_item(logic act, t_chan x, t_chan y, t_chan r, t_chan g,
                             t_chan b, logic [31:0] u, logic [31:0] v);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.texel_x <= x;
        in_ch.texel_y <= y;
        in_ch.texel_red <= r;
        in_ch.texel_green <= g;
        in_ch.texel_blue <= b;
        in_ch.coord_u <= u;
        in_ch.coord_v <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        if (act == ACT_WRITE) begin
            texels[{y, x}] = {r, g, b};
            written[{y, x}] = 1'b1;
        end else begin
            colors_due.push_back(blend_color(footprint(u, v)));
        end
    endtask

    task automatic write_texel(int x, int y);
        send_item(ACT_WRITE, t_chan'(x), t_chan'(y), t_chan'($urandom), t_chan'($urandom),
                  t_chan'($urandom), $urandom, $urandom);
    endtask

    task automatic make_present(int x, int y);
        if (!written[y*STORE_W + x]) write_texel(x, y);
    endtask

    task automatic sample_at(logic [31:0] u, logic [31:0] v);
        t_footprint f;
        f = footprint(u, v);
        make_present(f.x0, f.y0);
        make_present(f.x1, f.y0);
        make_present(f.x0, f.y1);
        make_present(f.x1, f.y1);
        send_item(ACT_SAMPLE, t_chan'($urandom), t_chan'($urandom), t_chan'($urandom),
                  t_chan'($urandom), t_chan'($urandom), u, v);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [CFG_DW-1:0] data);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BORDER: sh_border = data[1:0];
            CFG_FILTER: sh_filter = data[0];
            CFG_WIDTH:  sh_width = data;
            default:    sh_height = data;
        endcase
    endtask

    task automatic setup(logic [1:0] brd, logic flt, logic [CFG_DW-1:0] w,
                         logic [CFG_DW-1:0] h);
        set_reg(CFG_BORDER, CFG_DW'(brd));
        set_reg(CFG_FILTER, CFG_DW'(flt));
        set_reg(CFG_WIDTH, w);
        set_reg(CFG_HEIGHT, h);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 6*65536) - 3*65536;
            2: return ($urandom_range(0, 6) - 3) << 16;
            3: return 32'h10000 + $urandom_range(0, 8) - 4;
            4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            5: return $urandom_range(0, 65536);
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges [3];
        edges[0] = 32'h7fffffff;
        edges[1] = 32'h80000000;
        edges[2] = 32'h00010000;
        send_item(ACT_WRITE, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
        send_item(ACT_WRITE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff);
        for (int m = 0; m < 8; m++) begin
            setup(2'(m % 4), 1'(m / 4), 9'd256, 9'd256);
            for (int e = 0; e < 3; e++) sample_at(edges[e], edges[(e + 1) % 3]);
        end
    endtask

    task automatic run_phase(logic [1:0] brd, logic flt, logic [CFG_DW-1:0] w,
                             logic [CFG_DW-1:0] h, int samples);
        setup(brd, flt, w, h);
        for (int i = 0; i < samples; i++) begin
            if ($urandom_range(0, 7) == 0)
                write_texel($urandom_range(0, 255), $urandom_range(0, 255));
            sample_at(pick_coord(), pick_coord());
        end
    endtask

    task automatic test_random();
        logic [CFG_DW-1:0] sizes [10];
        sizes = '{9'd1, 9'd2, 9'd3, 9'd5, 9'd16, 9'd256, 9'd0, 9'd511, 9'd257, 9'd100};
        for (int ph = 0; ph < 12; ph++) begin
            run_phase(2'(ph % 4), 1'((ph / 2) % 2), sizes[$urandom_range(0, 9)],
                      sizes[$urandom_range(0, 9)], 55);
        end
        run_phase(BORDER_CLAMP, FILTER_BILINEAR, 9'd256, 9'd256, 25);
        run_phase(BORDER_MIRROR, FILTER_NEAREST, 9'd1, 9'd256, 25);
    endtask

    task automatic test_backpressure();
        setup(BORDER_MIRROR, FILTER_BILINEAR, 9'd8, 9'd8);
        for (int i = 0; i < 64; i++) sample_at(pick_coord(), pick_coord());
        hold_request = 400;
        for (int i = 0; i < 80; i++) sample_at(pick_coord(), pick_coord());
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        hold_request = 0;
        hold_left = 0;
        seg_left = 0;
        seg_kind = 0;
        sh_border = BORDER_REPEAT;
        sh_filter = FILTER_NEAREST;
        sh_width = 9'd256;
        sh_height = 9'd256;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_backpressure();

        in_ch.valid <= 1'b0;
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && colors_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
